>>> rtl/hpcc_pkg.sv
package hpcc_pkg;
  localparam int COUNT_BITS = 22;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W = 15;
  localparam int HUE_SCALE = 1 << HUE_FRAC_BITS;
  // numerator width: at most 360*64*255 < 2^23
  localparam int NUM_W = 23;
  localparam int DIV_W = 8;
  localparam int QUO_W = NUM_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [2:0] REG_HUE_A = 3'd0;
  localparam logic [2:0] REG_HUE_B = 3'd1;
  localparam logic [2:0] REG_MODE  = 3'd2;
  localparam logic [2:0] REG_TOL   = 3'd3;
  localparam logic [2:0] REG_VFLR  = 3'd4;
  localparam logic [2:0] REG_SFLR  = 3'd5;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_A    = 2'd1;
  localparam logic [1:0] CLS_B    = 2'd2;

  typedef struct packed {
    logic load;     // latch pixel, start filter/numerator
    logic div_step; // one quotient bit
    logic classify; // compare and update counts
  } cmd_t;

  typedef struct packed {
    logic pass;     // pixel passed the filters
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [14:0] hue_a;
    logic [14:0] hue_b;
    logic        mode;
    logic [13:0] tol;
    logic [7:0]  vflr;
    logic [9:0]  sflr;
  } cfg_t;
endpackage

>>> rtl/hpcc_if.sv
interface hpcc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       frame_start;
  modport source(output valid, blue, green, red, frame_start, input ready);
  modport sink(input valid, blue, green, red, frame_start, output ready);
endinterface

interface hpcc_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      pixel_class;
  logic [hpcc_pkg::HUE_W-1:0]      pixel_hue;
  logic [hpcc_pkg::COUNT_BITS-1:0] count_side_a;
  logic [hpcc_pkg::COUNT_BITS-1:0] count_side_b;
  modport source(output valid, pixel_class, pixel_hue, count_side_a, count_side_b,
                 input ready);
  modport sink(input valid, pixel_class, pixel_hue, count_side_a, count_side_b,
               output ready);
endinterface

interface hpcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/hpcc_ctrl.sv
module hpcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output hpcc_pkg::cmd_t cmd,
  input  hpcc_pkg::sts_t sts
);
  import hpcc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_CLS  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  // new item allowed once the previous result has left or leaves now
  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = sts.pass ? S_DIV : S_CLS;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_CLS;
      end
      S_CLS: begin
        cmd.classify = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.classify})) else $error("cmd overlap");
  a_cls_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.classify |=> out_valid) else $error("result lost");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
endmodule

>>> rtl/hpcc_dp.sv
module hpcc_dp (
  input  logic           clk,
  input  hpcc_pkg::cfg_t cfg,
  input  logic [7:0]     in_b,
  input  logic [7:0]     in_g,
  input  logic [7:0]     in_r,
  input  logic           in_fs,
  input  logic           rst_n,
  input  hpcc_pkg::cmd_t cmd,
  output hpcc_pkg::sts_t sts,
  output logic [1:0]     cls_o,
  output logic [14:0]    hue_o,
  output logic [hpcc_pkg::COUNT_BITS-1:0] cnt_a_o,
  output logic [hpcc_pkg::COUNT_BITS-1:0] cnt_b_o
);
  import hpcc_pkg::*;

  logic [7:0] b_r, g_r, r_r, hi_r, lo_r;
  logic [1:0] sel_r; // 0 blue max, 1 green, 2 red
  logic       pass_r, neg_r;
  logic [NUM_W-1:0] num_r, rem_r, quo_r;
  logic [4:0] bit_r;

  logic [7:0] bz, gz, rz, hi, lo;
  logic [9:0] sum;
  logic [12:0] lo17;
  logic [7:0] d;
  logic signed [9:0] diff;
  logic [1:0] sel;

  // zero forcing, max/min, blue-first tie order
  always_comb begin
    bz = (in_b == 8'd0) ? 8'd1 : in_b;
    gz = (in_g == 8'd0) ? 8'd1 : in_g;
    rz = (in_r == 8'd0) ? 8'd1 : in_r;
    hi = (bz >= gz) ? bz : gz;
    hi = (hi >= rz) ? hi : rz;
    lo = (bz <= gz) ? bz : gz;
    lo = (lo <= rz) ? lo : rz;
    sum = {2'b0, bz} + {2'b0, gz} + {2'b0, rz};
    if (hi == bz) sel = 2'd0;
    else if (hi == gz) sel = 2'd1;
    else sel = 2'd2;
  end

  assign lo17 = 13'd17 * {5'b0, lo_r};
  assign d = hi_r - lo_r;

  // signed channel difference of the max sector
  always_comb begin
    case (sel_r)
      2'd0: diff = $signed({2'b0, r_r}) - $signed({2'b0, g_r});
      2'd1: diff = $signed({2'b0, b_r}) - $signed({2'b0, r_r});
      default: diff = $signed({2'b0, g_r}) - $signed({2'b0, b_r});
    endcase
  end

  // numerator: 60*S*diff + offset*S*d
  logic signed [NUM_W+1:0] n60, noff, nsum;
  always_comb begin
    n60 = $signed({{(NUM_W-8){diff[9]}}, diff}) * $signed((NUM_W+2)'(60 * HUE_SCALE));
    case (sel_r)
      2'd0: noff = $signed({{(NUM_W-6){1'b0}}, d}) * $signed((NUM_W+2)'(240 * HUE_SCALE));
      2'd1: noff = $signed({{(NUM_W-6){1'b0}}, d}) * $signed((NUM_W+2)'(120 * HUE_SCALE));
      default: noff = (diff < 0) ?
        $signed({{(NUM_W-6){1'b0}}, d}) * $signed((NUM_W+2)'(360 * HUE_SCALE)) : '0;
    endcase
    nsum = n60 + noff;
  end

  logic [NUM_W-1:0] rsh;
  logic [NUM_W:0] sub;
  always_comb begin
    rsh = {rem_r[NUM_W-2:0], num_r[bit_r]};
    sub = {1'b0, rsh} - {{(NUM_W-7){1'b0}}, d};
  end

  // ratio test: some channel above 1.7 times the smallest
  logic ratio_ok;
  assign ratio_ok = (13'd10 * {5'b0, hi_r}) > lo17;
  logic chk_r;

  // pixel capture; ratio result folded in during the cycle after load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r <= bz; g_r <= gz; r_r <= rz; hi_r <= hi; lo_r <= lo; sel_r <= sel;
      pass_r <= (hi >= cfg.vflr) && (sum > cfg.sflr);
      neg_r <= in_fs;
    end else if (chk_r) begin
      pass_r <= pass_r && ratio_ok;
    end
  end

  // numerator capture and restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) chk_r <= 1'b0;
    else chk_r <= cmd.load;
    if (chk_r) begin
      num_r <= nsum[NUM_W-1:0];
      rem_r <= '0;
      quo_r <= '0;
      bit_r <= 5'(NUM_W - 1);
    end else if (cmd.div_step) begin
      if (!sub[NUM_W]) begin
        rem_r <= sub[NUM_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rsh;
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
      bit_r <= bit_r - 5'd1;
    end
  end

  assign sts.pass = pass_r && ratio_ok;
  assign sts.div_done = (bit_r == 5'd0);

  // classification
  logic [HUE_W-1:0] hue;
  assign hue = pass_r ? quo_r[HUE_W-1:0] : '0;
  logic signed [17:0] hs, xa, xb, tl;
  logic win_a, win_b, ha, hb;
  logic signed [19:0] t2, u2, h2, h2f, full;
  function automatic logic half(input logic signed [19:0] h, hf, x2, t, u, fl);
    logic signed [19:0] lo_v, hi_v;
    begin
      if (t <= x2 && x2 <= u) begin lo_v = t; hi_v = u; end
      else begin lo_v = u; hi_v = u + (fl >>> 1); end
      half = (lo_v <= h && h <= hi_v) || (lo_v <= hf && hf <= hi_v);
    end
  endfunction
  always_comb begin
    hs = $signed({3'b0, hue});
    xa = $signed({3'b0, cfg.hue_a});
    xb = $signed({3'b0, cfg.hue_b});
    tl = $signed({4'b0, cfg.tol});
    win_a = (xa - tl <= hs) && (hs <= xa + tl);
    win_b = (xb - tl <= hs) && (hs <= xb + tl);
    full = 20'(720 * HUE_SCALE);
    t2 = $signed({5'b0, cfg.hue_a}) + $signed({5'b0, cfg.hue_b});
    u2 = t2 + 20'(360 * HUE_SCALE);
    h2 = $signed({4'b0, hue, 1'b0});
    h2f = h2 + full;
    ha = half(h2, h2f, $signed({4'b0, cfg.hue_a, 1'b0}), t2, u2, full);
    hb = half(h2, h2f, $signed({4'b0, cfg.hue_b, 1'b0}), t2, u2, full);
  end

  logic [1:0] cls;
  always_comb begin
    cls = CLS_NONE;
    if (pass_r) begin
      if (cfg.mode) cls = win_a ? CLS_A : (win_b ? CLS_B : CLS_NONE);
      else cls = ha ? CLS_A : (hb ? CLS_B : CLS_NONE);
    end
  end

  // counters and result register
  logic [COUNT_BITS-1:0] ca_r, cb_r, ca, cb;
  always_comb begin
    ca = neg_r ? '0 : ca_r;
    cb = neg_r ? '0 : cb_r;
    if (cls == CLS_A && ca != COUNT_MAX) ca = ca + 1'b1;
    if (cls == CLS_B && cb != COUNT_MAX) cb = cb + 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0; cb_r <= '0;
    end else if (cmd.classify) begin
      ca_r <= ca; cb_r <= cb;
    end
    if (cmd.classify) begin
      cls_o <= cls; hue_o <= hue;
    end
  end
  assign cnt_a_o = ca_r;
  assign cnt_b_o = cb_r;

  a_hue_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.classify |-> (hue < HUE_W'(360 * HUE_SCALE))) else $error("hue range");
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.classify && !pass_r) |=> (hue_o == '0 && cls_o == CLS_NONE))
    else $error("drop not zero");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.classify && !neg_r && ca_r == COUNT_MAX) |=> ca_r == COUNT_MAX)
    else $error("count wrap");
endmodule

>>> rtl/hue_pixel_classifier_counter_top.sv
// channel | dir | handshake     | payload
// in_     | in  | valid/ready   | blue, green, red, frame_start
// out_    | out | valid/ready   | pixel_class, pixel_hue, count_side_a, count_side_b
// cfg_    | in  | valid/ready   | index (0..5), data
// A dropped item skips the divider; an item that passes the filters goes through the
// 23-bit restoring divider in the datapath, which produces one quotient bit per cycle.
// Synchronous active-low reset clears counts and control and sets config to defaults.
// The result sits in an output register; the next item is taken only once that
// result has left or leaves in the same cycle, otherwise input stalls.
module hue_pixel_classifier_counter_top (
  input logic clk,
  input logic rst_n,
  hpcc_pix_if.sink   in_ch,
  hpcc_res_if.source out_ch,
  hpcc_cfg_if.sink   cfg_ch
);
  import hpcc_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_a <= '0;
      cfg_r.hue_b <= '0;
      cfg_r.mode <= 1'b1;
      cfg_r.tol <= 14'd3840;
      cfg_r.vflr <= 8'd120;
      cfg_r.sflr <= 10'd110;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HUE_A: cfg_r.hue_a <= cfg_ch.data[14:0];
        REG_HUE_B: cfg_r.hue_b <= cfg_ch.data[14:0];
        REG_MODE:  cfg_r.mode <= cfg_ch.data[0];
        REG_TOL:   cfg_r.tol <= cfg_ch.data[13:0];
        REG_VFLR:  cfg_r.vflr <= cfg_ch.data[7:0];
        REG_SFLR:  cfg_r.sflr <= cfg_ch.data[9:0];
        default: ;
      endcase
    end
  end

  hpcc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  hpcc_dp u_dp (
    .clk(clk), .cfg(cfg_r),
    .in_b(in_ch.blue), .in_g(in_ch.green), .in_r(in_ch.red), .in_fs(in_ch.frame_start),
    .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cls_o(out_ch.pixel_class), .hue_o(out_ch.pixel_hue),
    .cnt_a_o(out_ch.count_side_a), .cnt_b_o(out_ch.count_side_b)
  );
endmodule

>>> tb/hpcc_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are defined with the RTL (hpcc_if.sv); this file only keeps the
// item records shared by the testbench.
package hpcc_tb_pkg;
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [1:0]                      pixel_class;
    logic [hpcc_pkg::HUE_W-1:0]      pixel_hue;
    logic [hpcc_pkg::COUNT_BITS-1:0] count_side_a;
    logic [hpcc_pkg::COUNT_BITS-1:0] count_side_b;
  } tally_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } reg_wr_t;
endpackage

>>> tb/tb_hue_pixel_classifier_counter_top.sv
`timescale 1ns / 1ps
module tb_hue_pixel_classifier_counter_top;
  import hpcc_pkg::*;
  import hpcc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hpcc_pix_if pix_ch();
  hpcc_res_if res_ch();
  hpcc_cfg_if cfg_ch();

  hue_pixel_classifier_counter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(pix_ch.sink),
    .out_ch(res_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [14:0] m_hue_a, m_hue_b;
  logic        m_mode;
  logic [13:0] m_tol;
  logic [7:0]  m_vflr;
  logic [9:0]  m_sflr;
  logic [COUNT_BITS-1:0] m_total_a, m_total_b;

  pixel_t  pixel_queue[$];
  tally_t  tally_queue[$];
  reg_wr_t reg_queue[$];

  int  mismatches = 0;
  bit  stim_done = 0;
  bit  quiet = 0;     // no idling in the last part of the run
  bit  pixel_hold = 0;
  int  stall_cycles = 0;
  int  pix_gap = 0;
  int  res_gap = 0;
  int  pixels_sent = 0;

  function automatic void write_model_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_HUE_A: m_hue_a = val[14:0];
      REG_HUE_B: m_hue_b = val[14:0];
      REG_MODE:  m_mode  = val[0];
      REG_TOL:   m_tol   = val[13:0];
      REG_VFLR:  m_vflr  = val[7:0];
      REG_SFLR:  m_sflr  = val[9:0];
      default: ;
    endcase
  endfunction

  // half-circle range test in doubled units
  function automatic bit in_half_circle(longint h2, longint x, longint t2, longint u2);
    longint full, lo, hi;
    full = 720 * HUE_SCALE;
    if (t2 <= 2 * x && 2 * x <= u2) begin
      lo = t2;
      hi = u2;
    end else begin
      lo = u2;
      hi = u2 + full / 2;
    end
    return (lo <= h2 && h2 <= hi) || (lo <= h2 + full && h2 + full <= hi);
  endfunction

  function automatic tally_t classify_pixel(pixel_t p);
    tally_t t;
    longint b, g, r, hi, lo, d, num, hue, tol, t2, u2, xa, xb;
    logic [1:0] cls;
    hue = 0;
    cls = CLS_NONE;
    if (p.frame_start) begin
      m_total_a = '0;
      m_total_b = '0;
    end
    b = (p.blue == 0) ? 1 : p.blue;
    g = (p.green == 0) ? 1 : p.green;
    r = (p.red == 0) ? 1 : p.red;
    hi = (b > g) ? b : g;
    hi = (hi > r) ? hi : r;
    lo = (b < g) ? b : g;
    lo = (lo < r) ? lo : r;
    if (hi >= m_vflr && b + g + r > m_sflr &&
        (10 * b > 17 * lo || 10 * g > 17 * lo || 10 * r > 17 * lo)) begin
      d = hi - lo;
      if (hi == b) num = 60 * HUE_SCALE * (r - g) + 240 * HUE_SCALE * d;
      else if (hi == g) num = 60 * HUE_SCALE * (b - r) + 120 * HUE_SCALE * d;
      else begin
        num = 60 * HUE_SCALE * (g - b);
        if (num < 0) num += 360 * HUE_SCALE * d;
      end
      hue = num / d;
      if (m_mode) begin
        tol = longint'(m_tol);
        xa = longint'(m_hue_a);
        xb = longint'(m_hue_b);
        if (xa - tol <= hue && hue <= xa + tol) cls = CLS_A;
        else if (xb - tol <= hue && hue <= xb + tol) cls = CLS_B;
      end else begin
        t2 = longint'(m_hue_a) + longint'(m_hue_b);
        u2 = t2 + 360 * HUE_SCALE;
        if (in_half_circle(2 * hue, m_hue_a, t2, u2)) cls = CLS_A;
        else if (in_half_circle(2 * hue, m_hue_b, t2, u2)) cls = CLS_B;
      end
      if (cls == CLS_A && m_total_a != COUNT_MAX) m_total_a++;
      if (cls == CLS_B && m_total_b != COUNT_MAX) m_total_b++;
    end
    t.pixel_class = cls;
    t.pixel_hue = hue[14:0];
    t.count_side_a = m_total_a;
    t.count_side_b = m_total_b;
    return t;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        tally_queue.push_back(classify_pixel(pixel_t'({pix_ch.blue, pix_ch.green,
                                                       pix_ch.red, pix_ch.frame_start})));
        pixels_sent++;
      end
      if (pix_ch.valid && !pix_ch.ready) begin
        // hold the item
      end else if (pix_gap > 0) begin
        pix_gap--;
        pix_ch.valid <= 1'b0;
      end else if (pixel_queue.size() > 0 && !pixel_hold) begin
        pixel_t p;
        p = pixel_queue.pop_front();
        pix_ch.valid <= 1'b1;
        {pix_ch.blue, pix_ch.green, pix_ch.red, pix_ch.frame_start} <= p;
        if (!quiet && $urandom_range(0, 15) == 0) pix_gap = $urandom_range(1, 17);
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // config driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) write_model_reg(cfg_ch.index, cfg_ch.data);
      if (cfg_ch.valid && !cfg_ch.ready) begin
      end else if (reg_queue.size() > 0) begin
        reg_wr_t w;
        w = reg_queue.pop_front();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= w.index;
        cfg_ch.data <= w.data;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        tally_t got, want;
        got = {res_ch.pixel_class, res_ch.pixel_hue, res_ch.count_side_a,
               res_ch.count_side_b};
        if (tally_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          want = tally_queue.pop_front();
          if (got.pixel_class !== want.pixel_class || got.pixel_hue !== want.pixel_hue ||
              got.count_side_a !== want.count_side_a ||
              got.count_side_b !== want.count_side_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: class %0d/%0d hue %0d/%0d cnt_a %0d/%0d cnt_b %0d/%0d",
                       want.pixel_class, got.pixel_class, want.pixel_hue, got.pixel_hue,
                       want.count_side_a, got.count_side_a,
                       want.count_side_b, got.count_side_b);
          end
        end
      end
      if (res_gap > 0) begin
        res_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 15) == 0) res_gap = $urandom_range(1, 17);
      end
    end
  end

  // watchdog on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic add_pixel(int b, int g, int r, bit fs);
    pixel_t p;
    p.blue = 8'(b);
    p.green = 8'(g);
    p.red = 8'(r);
    p.frame_start = fs;
    pixel_queue.push_back(p);
  endtask

  task automatic add_random_pixel();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6)      // vivid colors, mostly classified
      add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(120, 255),
                $urandom_range(0, 40) == 0);
    else if (kind < 8) // fully random, includes zeros
      add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 1));
    else               // near-gray, exercises the ratio test
      begin
        int base;
        base = $urandom_range(60, 150);
        add_pixel(base + $urandom_range(0, 105), base + $urandom_range(0, 105), base,
                  $urandom_range(0, 40) == 0);
      end
  endtask

  task automatic set_reg(logic [2:0] idx, int val);
    reg_wr_t w;
    w.index = idx;
    w.data = 16'(val);
    reg_queue.push_back(w);
  endtask

  // wait until the block is idle, then a little more
  task automatic wait_idle();
    wait (pixel_queue.size() == 0 && !pix_ch.valid && tally_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic wait_regs();
    wait (reg_queue.size() == 0);
    @(posedge clk);
    wait (!cfg_ch.valid);
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) add_random_pixel();
    wait_idle();
  endtask

  initial begin
    int phase;
    pix_ch.valid = 1'b0;
    pix_ch.blue = '0;
    pix_ch.green = '0;
    pix_ch.red = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    m_hue_a = '0; m_hue_b = '0; m_mode = 1'b1; m_tol = 14'd3840;
    m_vflr = 8'd120; m_sflr = 10'd110;
    m_total_a = '0; m_total_b = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, hue A near red, B near blue
    set_reg(REG_HUE_A, 0);
    set_reg(REG_HUE_B, 240 * 64);
    wait_regs();
    add_pixel(0, 0, 255, 1);       // pure red, zeros forced to 1
    add_pixel(255, 0, 0, 0);       // pure blue
    add_pixel(0, 255, 0, 0);       // pure green, no side in window
    add_pixel(255, 255, 255, 0);   // gray fails ratio test
    add_pixel(0, 0, 0, 0);         // black
    add_pixel(100, 10, 10, 0);     // below value floor
    add_pixel(255, 255, 1, 0);     // blue/green tie, blue wins
    add_pixel(1, 255, 255, 0);     // green/red tie
    add_pixel(30, 1, 255, 0);      // red max, negative branch wraps
    add_pixel(170, 100, 200, 0);   // blue exactly 1.7x the smallest, red above
    add_pixel(171, 100, 200, 0);
    add_pixel(255, 128, 64, 1);    // frame start mid-run
    add_pixel(255, 250, 245, 0);   // bright near-gray, large smallest channel
    wait_idle();

    // register extremes and bisection mode
    set_reg(REG_MODE, 0);
    set_reg(REG_VFLR, 0);
    set_reg(REG_SFLR, 0);
    set_reg(REG_TOL, 0);
    wait_regs();
    add_pixel(255, 1, 1, 0);
    add_pixel(1, 1, 255, 0);
    add_pixel(1, 255, 1, 0);
    add_pixel(3, 2, 1, 0);
    add_pixel(200, 90, 40, 0);
    wait_idle();
    set_reg(REG_VFLR, 255);
    set_reg(REG_SFLR, 765);
    set_reg(REG_HUE_A, 23039);
    set_reg(REG_HUE_B, 23039);
    wait_regs();
    add_pixel(255, 255, 255, 0);
    add_pixel(255, 1, 255, 0);
    add_pixel(1, 1, 255, 0);
    wait_idle();

    // random phases over several settings
    for (phase = 0; phase < 9; phase++) begin
      set_reg(REG_HUE_A, $urandom_range(0, 23039));
      set_reg(REG_HUE_B, (phase == 4) ? 32767 : $urandom_range(0, 23039));
      set_reg(REG_MODE, phase % 2);
      set_reg(REG_TOL, (phase == 3) ? 11520 : (phase == 5) ? 16383 :
                       $urandom_range(0, 11520));
      set_reg(REG_VFLR, (phase == 6) ? 0 : $urandom_range(0, 160));
      set_reg(REG_SFLR, (phase == 6) ? 1023 : $urandom_range(0, 300));
      wait_regs();
      if (phase == 8) quiet = 1;
      repeat (100) add_random_pixel();
      // sender pauses until all results are in
      if (phase == 2) begin
        pixel_hold = 1;
        wait (tally_queue.size() == 0 && !pix_ch.valid);
        repeat (DRAIN_CYCLES) @(posedge clk);
        pixel_hold = 0;
      end
      run_random(100);
    end

    wait_idle();
    if (mismatches == 0 && tally_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
